[hdl/frq_pkg.sv]
// Package for the fixed-window request quota block.
// Holds the shared types, register indexes, item kinds and constants.
// No dependencies.
package frq_pkg;

    // Length of one minute window in milliseconds.
    localparam logic [31:0] WINDOW_MS = 32'd60000;

    // Reset values of the configuration registers.
    localparam logic [31:0] DAILY_LIMIT_RST  = 32'd500;
    localparam logic [31:0] MINUTE_LIMIT_RST = 32'd15;

    // Stored day value meaning the day is not yet known.
    localparam logic signed [9:0] DAY_UNKNOWN = -10'sd1;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_DAILY_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_LIMIT = 1'd1;

    // Item kinds; the unused code behaves like a query.
    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic [31:0] daily_limit;
        logic [31:0] minute_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        now_ms;
        logic signed [9:0]  day_number;
        logic [31:0]        prompt_tokens;
        logic [31:0]        response_tokens;
        logic [31:0]        total_tokens;
    } item_t;

    typedef struct packed {
        logic        allowed;
        logic [31:0] count_today;
        logic [31:0] count_minute;
        logic [31:0] prompt_sum;
        logic [31:0] response_sum;
        logic [31:0] token_sum;
    } result_t;

endpackage

[hdl/frq_if.sv]
// Channel interfaces for the request quota block: request words in,
// result words out, each with valid/ready handshake. No dependencies.
interface frq_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [31:0]        now_ms;
    logic signed [9:0]  day_number;
    logic [31:0]        prompt_tokens;
    logic [31:0]        response_tokens;
    logic [31:0]        total_tokens;

    modport source (
        output valid, kind, now_ms, day_number, prompt_tokens, response_tokens,
               total_tokens,
        input  ready
    );
    modport sink (
        input  valid, kind, now_ms, day_number, prompt_tokens, response_tokens,
               total_tokens,
        output ready
    );
endinterface

interface frq_rsp_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic [31:0] count_today;
    logic [31:0] count_minute;
    logic [31:0] prompt_sum;
    logic [31:0] response_sum;
    logic [31:0] token_sum;

    modport source (
        output valid, allowed, count_today, count_minute, prompt_sum,
               response_sum, token_sum,
        input  ready
    );
    modport sink (
        input  valid, allowed, count_today, count_minute, prompt_sum,
               response_sum, token_sum,
        output ready
    );
endinterface

[hdl/frq_cfg_regs.sv]
// Configuration registers of the request quota block (daily and minute limits).
// Depends on frq_pkg.
module frq_cfg_regs
    import frq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [31:0] daily_limit_reg;
    logic [31:0] daily_limit_next;
    logic [31:0] minute_limit_reg;
    logic [31:0] minute_limit_next;

    // Decode the write to the addressed register.
    always_comb
    begin
        daily_limit_next  = daily_limit_reg;
        minute_limit_next = minute_limit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DAILY_LIMIT:  daily_limit_next  = cfg_data;
                CFG_MINUTE_LIMIT: minute_limit_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            daily_limit_reg  <= DAILY_LIMIT_RST;
            minute_limit_reg <= MINUTE_LIMIT_RST;
        end
        else
        begin
            daily_limit_reg  <= daily_limit_next;
            minute_limit_reg <= minute_limit_next;
        end
    end

    assign cfg.daily_limit  = daily_limit_reg;
    assign cfg.minute_limit = minute_limit_reg;

endmodule

[hdl/frq_core.sv]
// Quota state and per-word update: day and window counters, token sums,
// and the allow verdict for the result word. Depends on frq_pkg.
module frq_core
    import frq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic signed [9:0] stored_day_reg;
    logic signed [9:0] stored_day_next;
    logic [31:0]       window_start_reg;
    logic [31:0]       window_start_next;
    logic [31:0]       day_requests_reg;
    logic [31:0]       day_requests_next;
    logic [31:0]       window_requests_reg;
    logic [31:0]       window_requests_next;
    logic [31:0]       day_prompt_reg;
    logic [31:0]       day_prompt_next;
    logic [31:0]       day_response_reg;
    logic [31:0]       day_response_next;
    logic [31:0]       day_total_reg;
    logic [31:0]       day_total_next;

    logic        is_record;
    logic        is_clear;
    logic        expired_before;
    logic        expired_after;
    logic        new_day;
    logic        clear_day;
    logic        clear_window;
    logic [31:0] elapsed;

    // Decode the word kind.
    always_comb
    begin
        is_record = 1'b0;
        is_clear  = 1'b0;
        case (item.kind)
            KIND_RECORD: is_record = 1'b1;
            KIND_CLEAR:  is_clear  = 1'b1;
            KIND_QUERY:  ;
            default:     ;
        endcase
    end

    // Window age taken modulo 2^32, and the day change check.
    assign elapsed        = item.now_ms - window_start_reg;
    assign expired_before = (elapsed >= WINDOW_MS);
    assign new_day        = is_record && !item.day_number[9]
                            && (item.day_number != stored_day_reg);
    assign clear_day      = new_day || is_clear;
    assign clear_window   = is_clear || (is_record && expired_before);
    // A record word restarts an expired window, so it never sees it expired.
    assign expired_after  = expired_before && !is_record;

    // Next state after this word.
    always_comb
    begin
        stored_day_next   = new_day ? item.day_number : stored_day_reg;
        window_start_next = (is_record && expired_before) ? item.now_ms
                                                          : window_start_reg;
        day_requests_next    = (clear_day ? 32'd0 : day_requests_reg)
                               + {31'd0, is_record};
        window_requests_next = (clear_window ? 32'd0 : window_requests_reg)
                               + {31'd0, is_record};
        day_prompt_next   = (clear_day ? 32'd0 : day_prompt_reg)
                            + (is_record ? item.prompt_tokens : 32'd0);
        day_response_next = (clear_day ? 32'd0 : day_response_reg)
                            + (is_record ? item.response_tokens : 32'd0);
        day_total_next    = (clear_day ? 32'd0 : day_total_reg)
                            + (is_record ? item.total_tokens : 32'd0);
    end

    // Result word from the updated counters.
    always_comb
    begin
        result.allowed = !((!expired_after
                            && (window_requests_next >= cfg.minute_limit))
                           || ((cfg.daily_limit != 32'd0)
                               && (day_requests_next >= cfg.daily_limit)));
        result.count_today  = day_requests_next;
        result.count_minute = expired_after ? 32'd0 : window_requests_next;
        result.prompt_sum   = day_prompt_next;
        result.response_sum = day_response_next;
        result.token_sum    = day_total_next;
    end

    // State registers advance only when the word moves to the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_day_reg      <= DAY_UNKNOWN;
            window_start_reg    <= 32'd0;
            day_requests_reg    <= 32'd0;
            window_requests_reg <= 32'd0;
            day_prompt_reg      <= 32'd0;
            day_response_reg    <= 32'd0;
            day_total_reg       <= 32'd0;
        end
        else if (fire)
        begin
            stored_day_reg      <= stored_day_next;
            window_start_reg    <= window_start_next;
            day_requests_reg    <= day_requests_next;
            window_requests_reg <= window_requests_next;
            day_prompt_reg      <= day_prompt_next;
            day_response_reg    <= day_response_next;
            day_total_reg       <= day_total_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A clear word leaves every counter at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.kind == KIND_CLEAR |=>
            day_requests_reg == 32'd0 && window_requests_reg == 32'd0
            && day_prompt_reg == 32'd0 && day_response_reg == 32'd0
            && day_total_reg == 32'd0)
        else $error("clear word left a counter nonzero");

    // A query word changes no state.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.kind == KIND_QUERY |=>
            $stable(day_requests_reg) && $stable(window_requests_reg)
            && $stable(window_start_reg) && $stable(stored_day_reg)
            && $stable(day_total_reg))
        else $error("query word changed state");

    // The window start moves only on an accepted record word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && item.kind == KIND_RECORD) |=> $stable(window_start_reg))
        else $error("window start moved without a record word");
`endif

endmodule

[hdl/fixed_window_request_quota.sv]
// Top level of the fixed-window request quota block: input stage, quota
// core, result register. Depends on frq_pkg, frq_if, frq_cfg_regs, frq_core.
//
// Usage:
//   req carries request words (kind, now_ms, day_number, three token counts);
//   rsp carries one result word per request word (verdict and counters).
//   A word moves on a rising edge where valid and ready are both high.
//   The limits are written through cfg_we/cfg_index/cfg_data, index 0 the
//   daily limit and index 1 the minute limit, while no word is in flight.
//   A request word accepted on req enters the input register and then, once the
//   result register is free or being read, moves on into the result register.
//   Throughput: one word per cycle while rsp.ready stays high; the quota state
//   is read and rewritten as a word moves from the input to the result register.
//   Reset clears both stages, sets the limits to 500 per day and 15 per
//   window, marks the day unknown and zeroes all counters and the window.
//   When the receiver stalls, the result register holds its word and the
//   input stage still takes one more word; req.ready falls only when both
//   stages are full, and the stored state waits with the held word.
module fixed_window_request_quota
    import frq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    frq_req_if.sink               req,
    frq_rsp_if.source             rsp
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    logic    item_valid_next;
    result_t core_result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    result_valid_next;
    logic    stage_free;
    logic    advance;
    logic    take;

    frq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the result register frees when empty or being read.
    assign stage_free = !result_valid_reg || rsp.ready;
    assign advance    = item_valid_reg && stage_free;
    assign req.ready  = !item_valid_reg || stage_free;
    assign take       = req.valid && req.ready;

    assign item_valid_next   = take || (item_valid_reg && !stage_free);
    assign result_valid_next = advance || (result_valid_reg && !rsp.ready);

    frq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Input stage valid and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind            <= req.kind;
            item_reg.now_ms          <= req.now_ms;
            item_reg.day_number      <= req.day_number;
            item_reg.prompt_tokens   <= req.prompt_tokens;
            item_reg.response_tokens <= req.response_tokens;
            item_reg.total_tokens    <= req.total_tokens;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign rsp.valid        = result_valid_reg;
    assign rsp.allowed      = result_reg.allowed;
    assign rsp.count_today  = result_reg.count_today;
    assign rsp.count_minute = result_reg.count_minute;
    assign rsp.prompt_sum   = result_reg.prompt_sum;
    assign rsp.response_sum = result_reg.response_sum;
    assign rsp.token_sum    = result_reg.token_sum;

`ifndef NO_ASSERTIONS
    // Input back-pressure only when both stages are full and the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> item_valid_reg && rsp.valid && !rsp.ready)
        else $error("input stalled without a full pipeline");

    // A word leaving the input stage shows up as a result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp.valid)
        else $error("advanced word produced no result");

    // An accepted word is held in the input stage the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> item_valid_reg)
        else $error("accepted word lost from input stage");
`endif

endmodule
